### design/pidl_pkg.sv
`timescale 1ns / 1ps

package pidl_pkg;

    // wide enough for any supported capacity, plus one for the fill count
    localparam int IDX_BITS = 9;

    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_INSERT  = 2'd1;
    localparam logic [1:0] ACT_EXTRACT = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  position;
        logic [31:0] element_in;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [31:0] element_out;
        logic [4:0]  entries_held;
    } t_out_item;

    // broadcast to every cell in the row
    typedef struct packed {
        logic                ins;
        logic                ext;
        logic [IDX_BITS-1:0] pos;
        logic [IDX_BITS-1:0] count;
    } t_cell_ctrl;

endpackage

### design/pidl_cell.sv
`timescale 1ns / 1ps

module pidl_cell #(
    parameter int IDX          = 0,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                    i_clk,
    input  pidl_pkg::t_cell_ctrl    i_ctrl,
    input  logic [ELEMENT_BITS-1:0] i_elem,
    input  logic [ELEMENT_BITS-1:0] i_lower,
    input  logic [ELEMENT_BITS-1:0] i_upper,
    output logic [ELEMENT_BITS-1:0] o_val,
    output logic [ELEMENT_BITS-1:0] o_tap
);
    import pidl_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX   = IDX_BITS'(IDX);
    localparam logic [IDX_BITS-1:0] NEXT_IDX = IDX_BITS'(IDX + 1);

    logic [ELEMENT_BITS-1:0] r_val;
    logic [ELEMENT_BITS-1:0] n_val;

    always_comb begin
        n_val = r_val;
        priority if (i_ctrl.ins) begin
            if (MY_IDX == i_ctrl.pos) begin
                n_val = i_elem;
            end else if (MY_IDX > i_ctrl.pos && MY_IDX <= i_ctrl.count) begin
                n_val = i_lower;
            end
        end else if (i_ctrl.ext) begin
            // only the valid tail moves down; the vacated top slot keeps its value
            if (MY_IDX >= i_ctrl.pos && NEXT_IDX < i_ctrl.count) begin
                n_val = i_upper;
            end
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_tap = (MY_IDX == i_ctrl.pos) ? r_val : '0;

endmodule

### design/positional_insert_delete_list.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY elements held in a row of cells.
// Input channel (i_in_valid / o_in_stall / i_in_item) carries one action:
// read, insert or extract at a position. Insert moves the later elements up
// one cell, extract moves the valid tail down one cell, all cells in the
// same clock. Output channel (o_out_valid / i_out_stall / o_out_item) gives
// one result per action: ok, the element read or extracted (zero otherwise)
// and the fill count after the action.
// The result is registered and valid in the cycle after the transfer in. One
// action is taken every cycle unless the output stalls: the cell row updates
// at once behind one output register. While the receiver stalls with a result
// pending, the input stalls too; the result holds until it is taken.
// Reset (synchronous, active low) empties the list and drops any pending
// result. Cell contents are not cleared; only cells below the fill count are
// ever read.
module positional_insert_delete_list #(
    parameter int CAPACITY     = 16,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pidl_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pidl_pkg::t_out_item  o_out_item
);
    import pidl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IDX_BITS-1:0] CAP_IDX = IDX_BITS'(CAPACITY);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    t_out_item     r_out;
    t_out_item     n_out;

    logic                    accept;
    logic [IDX_BITS-1:0]     pos;
    logic [IDX_BITS-1:0]     cnt;
    logic                    hit;
    logic                    can_ins;
    logic                    rd_ok;
    logic                    ins_ok;
    logic                    ext_ok;
    t_cell_ctrl              ctrl;
    logic [ELEMENT_BITS-1:0] elem;
    logic [ELEMENT_BITS-1:0] read_val;

    logic [ELEMENT_BITS-1:0] cell_val [CAPACITY];
    logic [ELEMENT_BITS-1:0] cell_tap [CAPACITY];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign pos     = IDX_BITS'(i_in_item.position);
    assign cnt     = IDX_BITS'(r_count);
    assign hit     = pos < cnt;
    assign can_ins = (pos <= cnt) && (cnt < CAP_IDX);
    assign rd_ok   = (i_in_item.action == ACT_READ) && hit;
    assign ins_ok  = accept && (i_in_item.action == ACT_INSERT) && can_ins;
    assign ext_ok  = accept && (i_in_item.action == ACT_EXTRACT) && hit;
    assign elem    = ELEMENT_BITS'(i_in_item.element_in);

    assign ctrl.ins   = ins_ok;
    assign ctrl.ext   = ext_ok;
    assign ctrl.pos   = pos;
    assign ctrl.count = cnt;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEMENT_BITS-1:0] lower;
        logic [ELEMENT_BITS-1:0] upper;
        if (g == 0) begin : g_first
            assign lower = '0;
        end else begin : g_mid_lo
            assign lower = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign upper = '0;
        end else begin : g_mid_hi
            assign upper = cell_val[g+1];
        end
        pidl_cell #(
            .IDX          (g),
            .ELEMENT_BITS (ELEMENT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_elem  (elem),
            .i_lower (lower),
            .i_upper (upper),
            .o_val   (cell_val[g]),
            .o_tap   (cell_tap[g])
        );
    end

    // at most one tap is nonzero: the cell at the addressed position
    always_comb begin
        read_val = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            read_val = read_val | cell_tap[k];
        end
    end

    always_comb begin
        n_count = r_count;
        if (ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (ext_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (accept) begin
            n_out_valid        = 1'b1;
            n_out.ok           = rd_ok || ins_ok || ext_ok;
            n_out.element_out  = (rd_ok || ext_ok) ? 32'(read_val) : 32'd0;
            n_out.entries_held = 5'(n_count);
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### bench/positional_insert_delete_list_test.sv
`timescale 1ns / 1ps

module positional_insert_delete_list_test;
    import pidl_pkg::*;

    localparam int          LIST_DEPTH   = 16;
    localparam int          RANDOM_ITEMS = 1550;
    localparam int          HOLD_CYCLES  = 40;
    localparam int          HOLD_AT      = 300;
    localparam int          DRAIN_AT     = 900;
    localparam logic [1:0]  ACT_UNKNOWN  = 2'd3;

    typedef struct {
        t_in_item  item;
        bit        stated;
        t_out_item want;
    } t_plan_row;

    logic      i_clk     = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // shadow of the list
    logic [31:0] list_slots [LIST_DEPTH];
    int          list_count = 0;

    t_out_item   pending_results[$];
    t_plan_row   plan[$];
    bit          offer_stated = 1'b0;
    t_out_item   offer_want   = '0;
    bit          calm         = 1'b0;
    int          mismatch_count = 0;
    int          results_taken  = 0;

    positional_insert_delete_list dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_out_item list_apply(t_in_item it);
        t_out_item res;
        int k;
        res = '0;
        case (it.action)
            ACT_READ: begin
                if (it.position < list_count) begin
                    res.ok = 1'b1;
                    res.element_out = list_slots[it.position];
                end
            end
            ACT_INSERT: begin
                if (it.position <= list_count && list_count < LIST_DEPTH) begin
                    for (k = list_count; k > it.position; k--)
                        list_slots[k] = list_slots[k - 1];
                    list_slots[it.position] = it.element_in;
                    list_count++;
                    res.ok = 1'b1;
                end
            end
            ACT_EXTRACT: begin
                if (it.position < list_count) begin
                    res.element_out = list_slots[it.position];
                    // only the valid tail moves down
                    for (k = it.position; k + 1 < list_count; k++)
                        list_slots[k] = list_slots[k + 1];
                    list_count--;
                    res.ok = 1'b1;
                end
            end
            default: ;
        endcase
        res.entries_held = 5'(list_count);
        return res;
    endfunction

    // mostly positions inside the list so the fill count keeps moving
    function automatic t_in_item pick_action(int insert_pct);
        t_in_item it;
        int roll;
        it.element_in = $urandom;
        roll = $urandom_range(99);
        if (roll < 3)
            it.action = ACT_UNKNOWN;
        else if (roll < 3 + insert_pct)
            it.action = ACT_INSERT;
        else if (roll < 3 + insert_pct + (97 - insert_pct) / 2)
            it.action = ACT_EXTRACT;
        else
            it.action = ACT_READ;
        if ($urandom_range(99) < 12)
            it.position = 5'($urandom_range(31));
        else if (it.action == ACT_INSERT)
            it.position = 5'($urandom_range(list_count));
        else if (list_count == 0)
            it.position = 5'd0;
        else
            it.position = 5'($urandom_range(list_count - 1));
        return it;
    endfunction

    task automatic plan_row(logic [1:0] act, logic [4:0] pos, logic [31:0] elem);
        t_plan_row r;
        r.item = '{action: act, position: pos, element_in: elem};
        r.stated = 1'b0;
        r.want = '0;
        plan.insert(plan.size(), r);
    endtask

    task automatic plan_known(logic [1:0] act, logic [4:0] pos, logic [31:0] elem,
                              logic ok, logic [31:0] out, logic [4:0] held);
        t_plan_row r;
        r.item = '{action: act, position: pos, element_in: elem};
        r.stated = 1'b1;
        r.want = '{ok: ok, element_out: out, entries_held: held};
        plan.insert(plan.size(), r);
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_action(t_in_item it, bit stated, t_out_item want);
        while (!calm && $urandom_range(99) < 11) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        offer_stated = stated;
        offer_want = want;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (rst_n && in_valid && !o_in_stall) begin
            want = list_apply(in_item);
            if (offer_stated)
                want = offer_want;
            pending_results.insert(pending_results.size(), want);
        end
        if (rst_n && o_out_valid && !out_stall) begin
            results_taken++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: ok=%0b out=%h held=%0d",
                             o_out_item.ok, o_out_item.element_out,
                             o_out_item.entries_held);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.ok !== want.ok ||
                    o_out_item.element_out !== want.element_out ||
                    o_out_item.entries_held !== want.entries_held) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: expected ok=%0b out=%h held=%0d, ",
                                 results_taken, want.ok, want.element_out,
                                 want.entries_held,
                                 "got ok=%0b out=%h held=%0d", o_out_item.ok,
                                 o_out_item.element_out, o_out_item.entries_held);
                end
            end
        end
    end

    // result side: random stalls plus one long hold so the input backs up
    initial begin : result_sink
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_taken >= HOLD_AT) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            out_stall <= (!calm && $urandom_range(99) < 11);
        end
    end

    initial begin : stimulus
        int pct;
        repeat (6) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list: every access fails until the first insert at position 0
        plan_known(ACT_READ,    5'd0, 32'h0,         1'b0, 32'h0, 5'd0);
        plan_known(ACT_EXTRACT, 5'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 5'd0);
        plan_known(ACT_INSERT,  5'd1, 32'h1234_5678, 1'b0, 32'h0, 5'd0);
        plan_known(ACT_UNKNOWN, 5'd0, 32'h0,         1'b0, 32'h0, 5'd0);
        plan_known(ACT_INSERT,  5'd0, 32'hFFFF_FFFF, 1'b1, 32'h0, 5'd1);
        plan_known(ACT_READ,    5'd0, 32'h0,         1'b1, 32'hFFFF_FFFF, 5'd1);
        plan_known(ACT_INSERT,  5'd1, 32'h0,         1'b1, 32'h0, 5'd2);
        plan_row(ACT_INSERT, 5'd0, 32'hA5A5_5A5A);
        plan_known(ACT_READ,    5'd31, 32'h0,        1'b0, 32'h0, 5'd3);
        for (int i = 3; i < LIST_DEPTH; i++)
            plan_row(ACT_INSERT, 5'(i / 2), 32'hC3C3_0000 + i);
        // full list
        plan_known(ACT_INSERT,  5'd16, 32'hDEAD_BEEF, 1'b0, 32'h0, 5'd16);
        plan_known(ACT_INSERT,  5'd0,  32'h7FFF_FFFF, 1'b0, 32'h0, 5'd16);
        plan_row(ACT_READ,    5'd15, 32'h0);
        plan_row(ACT_EXTRACT, 5'd15, 32'h0);
        plan_row(ACT_EXTRACT, 5'd0,  32'h0);
        plan_known(ACT_EXTRACT, 5'd14, 32'h0,         1'b0, 32'h0, 5'd14);
        plan_row(ACT_READ,    5'd13, 32'h0);

        foreach (plan[i])
            send_action(plan[i].item, plan[i].stated, plan[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / 120) % 3)
                0:       pct = 70;
                1:       pct = 25;
                default: pct = 45;
            endcase
            calm = (n >= 500 && n < 700);
            if (n == DRAIN_AT) begin
                // let the pipe run dry before the next transfer
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            send_action(pick_action(pct), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
design/pidl_pkg.sv
design/pidl_cell.sv
design/positional_insert_delete_list.sv
bench/positional_insert_delete_list_test.sv
